@@ src/cop_pkg.sv @@
// ----------------------------------------------------------------------------
// cop_pkg: shared types, constants and tables for the compass offset block
// Holds the sine magnitude table, the quantized cosine ROM contents and the
// fixed-point constants used by the pipeline stages.
// ----------------------------------------------------------------------------
package cop_pkg;

	// cosine table resolution over 0..90 degrees
	localparam int COS_TABLE_BITS = 10;
	localparam int CT_N = (1 << COS_TABLE_BITS) + 1;
	localparam int IDXW = COS_TABLE_BITS + 1;
	localparam int CTW = 16;

	localparam int LAT_LIMIT = 9000;
	localparam int LON_LIMIT = 18000;

	// north part: round(d*100*cmag / (69*32768))
	localparam int DSW = 25;
	localparam int NPW = 33;
	localparam longint unsigned NDEN = 64'd4521984;
	localparam longint unsigned NHALF = 64'd2260992;
	localparam int NK = 33;
	localparam int NMW = 11;
	localparam longint unsigned NM = (64'd1 << NK) / NDEN;
	localparam int NQW = 11;

	// cosine index: round(|s| * 2^B / 18000)
	localparam int AW = 15;
	localparam int XW = AW + COS_TABLE_BITS;
	localparam int IMW = XW - 14;
	localparam longint unsigned IDIV = 64'd18000;
	localparam longint unsigned IM = (64'd1 << XW) / IDIV;

	// east part divider
	localparam int LNW = 33;
	localparam int LDW = 23;
	localparam int QW = 17;
	localparam int RW = LDW + QW;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [CTW-1:0] cos_rom_t [CT_N];

	// east-side payload that rides along the pipe
	typedef struct packed {
		logic signed [15:0] lon;
		logic [DSW-1:0] ds;
		logic east_neg;
		logic no_east;
	} east_t;

	// clamped latitude result
	typedef struct packed {
		logic signed [14:0] lat;
		logic flag;
	} latr_t;

	// magnitude of the Q1.15 sine of compass point k
	function automatic logic [14:0] sin_mag(input logic [3:0] k);
		logic [14:0] m;
		case (k[2:0])
			3'd0: m = k[3] ? 15'd0 : 15'd0;
			3'd1: m = 15'd12540;
			3'd2: m = 15'd23170;
			3'd3: m = 15'd30274;
			3'd4: m = 15'd32767;
			3'd5: m = 15'd30274;
			3'd6: m = 15'd23170;
			3'd7: m = 15'd12540;
			default: m = 15'd0;
		endcase
		return m;
	endfunction

	// sine of compass point k is negative
	function automatic logic sin_neg(input logic [3:0] k);
		return k[3] && (k[2:0] != 3'd0);
	endfunction

	// cosine table by a Q30 series to x^12, rounded to Q15
	// series terms divide by (2k-1)*2k: 2, 12, 30, 56, 90, 132
	function automatic cos_rom_t build_cos();
		cos_rom_t t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint sum;
		for (int i = 0; i < CT_N; i++) begin
			x = (64'(i) * HALF_PI_Q30) >> COS_TABLE_BITS;
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			sum = longint'(term);
			term = ((term * x2) >> 30) / 64'd2;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd12;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd30;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd56;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd90;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd132;
			sum = sum + longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > (longint'(1) << 30)) begin
				sum = longint'(1) << 30;
			end
			t[i] = CTW'((64'(sum) + 64'd16384) >> 15);
		end
		return t;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos();

endpackage

@@ src/cop_north.sv @@
// ----------------------------------------------------------------------------
// cop_north: north part of the move
// Three stages: distance times sine magnitudes, reciprocal multiply, then the
// rounding correction and sign.
// ----------------------------------------------------------------------------
module cop_north (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [14:0] in_lat,
	input  logic signed [15:0] in_lon,
	input  logic [9:0] in_dist,
	input  logic [3:0] in_dir,
	output logic out_vld,
	output logic signed [14:0] out_lat,
	output logic signed [cop_pkg::NQW:0] out_north,
	output cop_pkg::east_t out_east
);

	localparam int PRW = cop_pkg::NPW + cop_pkg::NMW;

	logic [3:0] cdir;
	logic [14:0] cmag;
	logic [14:0] smag;

	logic v_s1, v_s2, v_s3;
	logic [cop_pkg::DSW-1:0] dc_s1;
	logic nneg_s1, nneg_s2;
	logic signed [14:0] lat_s1, lat_s2, lat_s3;
	cop_pkg::east_t east_s1, east_s2, east_s3;

	logic [cop_pkg::NPW-1:0] p_c;
	logic [PRW-1:0] prod_c;
	logic [cop_pkg::NPW-1:0] p_s2;
	logic [cop_pkg::NQW-1:0] q0_s2;

	logic [cop_pkg::NPW-1:0] r_c;
	logic [cop_pkg::NQW-1:0] mag_c;
	logic signed [cop_pkg::NQW:0] north_s3;

	// stage 1: table lookups and distance products
	assign cdir = in_dir + 4'd4;
	assign cmag = cop_pkg::sin_mag(cdir);
	assign smag = cop_pkg::sin_mag(in_dir);

	// stage 2: rounded numerator and reciprocal product
	assign p_c = cop_pkg::NPW'(dc_s1) * cop_pkg::NPW'(200) + cop_pkg::NPW'(cop_pkg::NHALF);
	assign prod_c = PRW'(p_c) * PRW'(cop_pkg::NM);

	// stage 3: one-step correction
	assign r_c = p_s2 - cop_pkg::NPW'(q0_s2) * cop_pkg::NPW'(cop_pkg::NDEN);
	assign mag_c = q0_s2 + cop_pkg::NQW'(r_c >= cop_pkg::NPW'(cop_pkg::NDEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dc_s1 <= cop_pkg::DSW'(in_dist) * cop_pkg::DSW'(cmag);
		nneg_s1 <= cop_pkg::sin_neg(cdir);
		lat_s1 <= in_lat;
		east_s1.lon <= in_lon;
		east_s1.ds <= cop_pkg::DSW'(in_dist) * cop_pkg::DSW'(smag);
		east_s1.east_neg <= cop_pkg::sin_neg(in_dir);
		east_s1.no_east <= (in_dist == 10'd0) || (smag == 15'd0);

		p_s2 <= p_c;
		q0_s2 <= cop_pkg::NQW'(prod_c >> cop_pkg::NK);
		nneg_s2 <= nneg_s1;
		lat_s2 <= lat_s1;
		east_s2 <= east_s1;

		north_s3 <= nneg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		lat_s3 <= lat_s2;
		east_s3 <= east_s2;
	end

	assign out_vld = v_s3;
	assign out_lat = lat_s3;
	assign out_north = north_s3;
	assign out_east = east_s3;

endmodule

@@ src/cop_cidx.sv @@
// ----------------------------------------------------------------------------
// cop_cidx: new latitude and cosine of the mean latitude
// Clamps the new latitude, forms the cosine table index by a reciprocal
// multiply with correction, and reads the cosine ROM.
// ----------------------------------------------------------------------------
module cop_cidx (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [14:0] in_lat,
	input  logic signed [cop_pkg::NQW:0] in_north,
	input  cop_pkg::east_t in_east,
	output logic out_vld,
	output logic [cop_pkg::CTW-1:0] out_ctab,
	output cop_pkg::latr_t out_latr,
	output cop_pkg::east_t out_east
);

	localparam int XPW = cop_pkg::XW + cop_pkg::IMW;

	logic signed [15:0] lat_raw;
	logic signed [16:0] s_c;
	logic [16:0] sa_c;
	logic [cop_pkg::AW-1:0] as_c;
	cop_pkg::latr_t latr_c;

	logic v_s4, v_s5, v_s6, v_s7;
	logic [cop_pkg::XW-1:0] x_s4, x_s5;
	cop_pkg::latr_t latr_s4, latr_s5, latr_s6, latr_s7;
	cop_pkg::east_t east_s4, east_s5, east_s6, east_s7;

	logic [XPW-1:0] xp_c;
	logic [cop_pkg::IDXW-1:0] q0_s5;
	logic [cop_pkg::XW-1:0] r_c;
	logic [cop_pkg::IDXW-1:0] idx_s6;
	logic [cop_pkg::CTW-1:0] ctab_s7;

	// stage 4: new latitude, clamp, mean-latitude magnitude
	assign lat_raw = 16'(in_lat) + 16'(in_north);
	assign s_c = 17'(in_lat) + 17'(lat_raw);
	assign sa_c = s_c[16] ? 17'(-s_c) : 17'(s_c);
	assign as_c = (sa_c > 17'(2 * cop_pkg::LAT_LIMIT)) ?
		cop_pkg::AW'(2 * cop_pkg::LAT_LIMIT) : cop_pkg::AW'(sa_c);

	always_comb begin
		latr_c.flag = 1'b0;
		latr_c.lat = 15'(lat_raw);
		if (lat_raw > 16'sd9000) begin
			latr_c.lat = 15'(cop_pkg::LAT_LIMIT);
			latr_c.flag = 1'b1;
		end else if (lat_raw < -16'sd9000) begin
			latr_c.lat = 15'(-cop_pkg::LAT_LIMIT);
			latr_c.flag = 1'b1;
		end
	end

	// stage 5: reciprocal product; stage 6: correction
	assign xp_c = XPW'(x_s4) * XPW'(cop_pkg::IM);
	assign r_c = x_s5 - cop_pkg::XW'(q0_s5) * cop_pkg::XW'(cop_pkg::IDIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s4 <= in_vld;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		x_s4 <= (cop_pkg::XW'(as_c) << cop_pkg::COS_TABLE_BITS) + cop_pkg::XW'(cop_pkg::LAT_LIMIT);
		latr_s4 <= latr_c;
		east_s4 <= in_east;

		x_s5 <= x_s4;
		q0_s5 <= cop_pkg::IDXW'(xp_c >> cop_pkg::XW);
		latr_s5 <= latr_s4;
		east_s5 <= east_s4;

		idx_s6 <= q0_s5 + cop_pkg::IDXW'(r_c >= cop_pkg::XW'(cop_pkg::IDIV));
		latr_s6 <= latr_s5;
		east_s6 <= east_s5;

		// stage 7: registered cosine ROM read
		ctab_s7 <= cop_pkg::COS_ROM[idx_s6];
		latr_s7 <= latr_s6;
		east_s7 <= east_s6;
	end

	assign out_vld = v_s7;
	assign out_ctab = ctab_s7;
	assign out_latr = latr_s7;
	assign out_east = east_s7;

endmodule

@@ src/cop_ldiv.sv @@
// ----------------------------------------------------------------------------
// cop_ldiv: east part divided by the cosine
// Forms the rounded numerator and divisor, then a restoring divider with one
// quotient bit per stage. Quotients too wide for the 17-bit quotient, and a
// zero cosine, raise the overflow bit.
// ----------------------------------------------------------------------------
module cop_ldiv (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [cop_pkg::CTW-1:0] in_ctab,
	input  cop_pkg::latr_t in_latr,
	input  cop_pkg::east_t in_east,
	output logic out_vld,
	output logic [cop_pkg::QW-1:0] out_q,
	output logic out_ovf,
	output cop_pkg::latr_t out_latr,
	output cop_pkg::east_t out_east
);

	localparam int QW = cop_pkg::QW;

	logic vld_d [0:QW];
	logic [cop_pkg::LNW-1:0] rem_d [0:QW];
	logic [cop_pkg::LDW-1:0] dv_d [0:QW];
	logic [QW-1:0] q_d [0:QW];
	logic ovf_d [1:QW];
	cop_pkg::latr_t latr_d [0:QW];
	cop_pkg::east_t east_d [0:QW];

	// stage 8: numerator 2*d*100*smag + 69*ctab, divisor 138*ctab
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d[0] <= 1'b0;
		end else begin
			vld_d[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_d[0] <= cop_pkg::LNW'(in_east.ds) * cop_pkg::LNW'(200) +
			cop_pkg::LNW'(in_ctab) * cop_pkg::LNW'(69);
		dv_d[0] <= cop_pkg::LDW'(in_ctab) * cop_pkg::LDW'(138);
		q_d[0] <= '0;
		latr_d[0] <= in_latr;
		east_d[0] <= in_east;
	end

	// divider stages, most significant quotient bit first
	for (genvar g = 0; g < QW; g++) begin : g_div
		localparam int SH = QW - 1 - g;
		logic [cop_pkg::RW-1:0] cmp;
		logic [cop_pkg::RW-1:0] shd;
		logic ge;
		logic ovf_c;

		assign cmp = cop_pkg::RW'(rem_d[g]);
		assign shd = cop_pkg::RW'(dv_d[g]) << SH;
		assign ge = (cmp >= shd);

		if (g == 0) begin : g_first
			assign ovf_c = (cmp >= (cop_pkg::RW'(dv_d[g]) << QW));
		end else begin : g_rest
			assign ovf_c = ovf_d[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[g+1] <= 1'b0;
			end else begin
				vld_d[g+1] <= vld_d[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_d[g+1] <= ge ? cop_pkg::LNW'(cmp - shd) : rem_d[g];
			dv_d[g+1] <= dv_d[g];
			q_d[g+1] <= {q_d[g][QW-2:0], ge};
			ovf_d[g+1] <= ovf_c;
			latr_d[g+1] <= latr_d[g];
			east_d[g+1] <= east_d[g];
		end
	end

	assign out_vld = vld_d[QW];
	assign out_q = q_d[QW];
	assign out_ovf = ovf_d[QW];
	assign out_latr = latr_d[QW];
	assign out_east = east_d[QW];

endmodule

@@ src/compass_offset_position.sv @@
// ----------------------------------------------------------------------------
// compass_offset_position: flat-earth offset of a position along a compass point
// Moves a latitude/longitude (hundredths of a degree) by a distance in miles
// along one of sixteen compass points, saturating the result.
// ----------------------------------------------------------------------------
// The block is a fixed pipeline: it takes one item in every clock cycle and
// never raises busy. Each item's result appears on done after the pipeline
// stages (3 stages for the north part, 4 for the latitude, cosine index
// and cosine ROM read, 18 for the east-part divider: one setup stage, then one
// quotient bit per stage, plus the output register). The receiver cannot
// stall: results must be taken in the cycle done is high.
module compass_offset_position (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [14:0] start_lat,
	input  logic signed [15:0] start_lon,
	input  logic [9:0] distance_miles,
	input  logic [3:0] direction,
	output logic done,
	output logic signed [14:0] end_lat,
	output logic signed [15:0] end_lon,
	output logic range_flag
);

	logic n_vld;
	logic signed [14:0] n_lat;
	logic signed [cop_pkg::NQW:0] n_north;
	cop_pkg::east_t n_east;

	logic c_vld;
	logic [cop_pkg::CTW-1:0] c_ctab;
	cop_pkg::latr_t c_latr;
	cop_pkg::east_t c_east;

	logic d_vld;
	logic [cop_pkg::QW-1:0] d_q;
	logic d_ovf;
	cop_pkg::latr_t d_latr;
	cop_pkg::east_t d_east;

	logic signed [18:0] lon_raw;
	logic signed [18:0] dlon;
	logic signed [15:0] lon_c;
	logic lon_flag;

	logic done_q;
	logic signed [14:0] lat_q;
	logic signed [15:0] lon_q;
	logic flag_q;

	assign busy = 1'b0;

	cop_north u_north (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.in_lat    (start_lat),
		.in_lon    (start_lon),
		.in_dist   (distance_miles),
		.in_dir    (direction),
		.out_vld   (n_vld),
		.out_lat   (n_lat),
		.out_north (n_north),
		.out_east  (n_east)
	);

	cop_cidx u_cidx (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (n_vld),
		.in_lat   (n_lat),
		.in_north (n_north),
		.in_east  (n_east),
		.out_vld  (c_vld),
		.out_ctab (c_ctab),
		.out_latr (c_latr),
		.out_east (c_east)
	);

	cop_ldiv u_ldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (c_vld),
		.in_ctab  (c_ctab),
		.in_latr  (c_latr),
		.in_east  (c_east),
		.out_vld  (d_vld),
		.out_q    (d_q),
		.out_ovf  (d_ovf),
		.out_latr (d_latr),
		.out_east (d_east)
	);

	// longitude: add the signed east part, overflow goes past the limit
	assign dlon = $signed(19'(d_q));

	always_comb begin
		if (d_east.no_east) begin
			lon_raw = 19'(d_east.lon);
		end else if (d_ovf) begin
			lon_raw = d_east.east_neg ? 19'(-cop_pkg::LON_LIMIT - 1) : 19'(cop_pkg::LON_LIMIT + 1);
		end else if (d_east.east_neg) begin
			lon_raw = 19'(d_east.lon) - dlon;
		end else begin
			lon_raw = 19'(d_east.lon) + dlon;
		end
	end

	// saturate longitude
	always_comb begin
		lon_flag = 1'b0;
		lon_c = 16'(lon_raw);
		if (lon_raw > 19'sd18000) begin
			lon_c = 16'(cop_pkg::LON_LIMIT);
			lon_flag = 1'b1;
		end else if (lon_raw < -19'sd18000) begin
			lon_c = 16'(-cop_pkg::LON_LIMIT);
			lon_flag = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		lat_q <= d_latr.lat;
		lon_q <= lon_c;
		flag_q <= d_latr.flag | lon_flag;
	end

	assign done = done_q;
	assign end_lat = lat_q;
	assign end_lon = lon_q;
	assign range_flag = flag_q;

endmodule

@@ tb/sv/tb_compass_offset_position.sv @@
// ----------------------------------------------------------------------------
// tb_compass_offset_position: self-checking bench for the compass offset block
// Drives directed corner positions and random moves with random start gaps,
// predicts each item's result in a scoreboard and checks every done strobe.
// ----------------------------------------------------------------------------
module tb_compass_offset_position;

	// one predicted result
	typedef struct {
		logic signed [14:0] lat;
		logic signed [15:0] lon;
		logic flag;
	} fix_t;

	// position scoreboard: predicts moves and checks results in order
	class offset_board;
		fix_t pending[$];
		int errors;
		int shown;

		function new();
			errors = 0;
			shown = 0;
		endfunction

		// Q15 sine of compass point k, signed
		function automatic longint sine_q15(input int k);
			longint mag[8];
			longint m;
			mag = '{0, 12540, 23170, 30274, 32767, 30274, 23170, 12540};
			m = mag[k % 8];
			return (k >= 8) ? -m : m;
		endfunction

		// cosine of table index i, Q15 via Q30 series
		function automatic longint unsigned cos_at(input longint unsigned i);
			longint unsigned x, x2, term;
			longint sum;
			x = (i * 64'd1686629713) >> cop_pkg::COS_TABLE_BITS;
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			sum = longint'(term);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * x2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
				if (k % 2 == 1) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
			return (64'(sum) + 64'd16384) >> 15;
		endfunction

		// rounded quotient, half away from zero
		function automatic longint rdiv(input longint unsigned num, input bit neg,
				input longint unsigned den);
			longint unsigned q;
			q = (2 * num + den) / (2 * den);
			return neg ? -longint'(q) : longint'(q);
		endfunction

		// note an accepted item and predict its result
		function void note_move(input logic signed [14:0] lat0,
				input logic signed [15:0] lon0, input logic [9:0] miles, input logic [3:0] dir);
			longint sv, cv, north, lat_raw, s, lon_raw;
			longint unsigned d, as, idx, ctab;
			fix_t r;
			d = miles;
			sv = sine_q15(dir);
			cv = sine_q15((dir + 4) % 16);
			north = rdiv(d * 100 * (cv < 0 ? -cv : cv), cv < 0, 64'd69 * 32768);
			lat_raw = lat0 + north;
			s = lat0 + lat_raw;
			as = s < 0 ? -s : s;
			if (as > 18000) as = 18000;
			idx = ((as << cop_pkg::COS_TABLE_BITS) + 9000) / 18000;
			ctab = cos_at(idx);
			if (d == 0 || sv == 0) lon_raw = lon0;
			else if (ctab == 0) lon_raw = sv < 0 ? -18001 : 18001;
			else lon_raw = lon0 + rdiv(d * 100 * (sv < 0 ? -sv : sv), sv < 0, 69 * ctab);
			r.flag = 0;
			if (lat_raw > 9000) begin lat_raw = 9000; r.flag = 1; end
			if (lat_raw < -9000) begin lat_raw = -9000; r.flag = 1; end
			if (lon_raw > 18000) begin lon_raw = 18000; r.flag = 1; end
			if (lon_raw < -18000) begin lon_raw = -18000; r.flag = 1; end
			r.lat = lat_raw[14:0];
			r.lon = lon_raw[15:0];
			pending.push_back(r);
		endfunction

		// compare one result with the oldest prediction
		function void check_result(input logic signed [14:0] lat,
				input logic signed [15:0] lon, input logic flag);
			fix_t e;
			if (pending.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result lat=%0d lon=%0d flag=%0b", lat, lon, flag);
				end
				return;
			end
			e = pending.pop_front();
			if (lat !== e.lat || lon !== e.lon || flag !== e.flag) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch: exp lat=%0d lon=%0d flag=%0b, got lat=%0d lon=%0d flag=%0b",
						e.lat, e.lon, e.flag, lat, lon, flag);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [14:0] start_lat = '0;
	logic signed [15:0] start_lon = '0;
	logic [9:0] distance_miles = '0;
	logic [3:0] direction = '0;
	logic busy, done, range_flag;
	logic signed [14:0] end_lat;
	logic signed [15:0] end_lon;

	offset_board board = new();

	compass_offset_position dut (.*);

	always #10 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) board.check_result(end_lat, end_lon, range_flag);
	end

	// present one item, hold start until accepted, then idle a random gap
	task automatic send_move(input logic signed [14:0] lat, input logic signed [15:0] lon,
			input logic [9:0] miles, input logic [3:0] dir);
		int gap;
		start <= 1;
		start_lat <= lat;
		start_lon <= lon;
		distance_miles <= miles;
		direction <= dir;
		do @(posedge clk); while (busy);
		board.note_move(lat, lon, miles, dir);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random latitude, mostly legal with some out of range
	function automatic logic [14:0] pick_lat();
		if ($urandom_range(0, 9) == 0) return 15'($urandom);
		return 15'($signed($urandom_range(0, 18000)) - 9000);
	endfunction

	function automatic logic [15:0] pick_lon();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 36000)) - 18000);
	endfunction

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: every direction at full distance from the origin
		for (int k = 0; k < 16; k++) send_move(0, 0, 10'd1023, 4'(k));
		// poles, date line, zero distance, out-of-range fields
		send_move(15'sd9000, 16'sd18000, 10'd1023, 4'd2);
		send_move(-15'sd9000, -16'sd18000, 10'd1023, 4'd10);
		send_move(15'sd8990, 16'sd0, 10'd500, 4'd4);
		send_move(15'sd9000, 16'sd100, 10'd0, 4'd5);
		send_move(15'h3FFF, 16'h7FFF, 10'd1023, 4'd0);
		send_move(15'h4000, 16'h8000, 10'd1023, 4'd8);
		send_move(15'sd8000, 16'sd17000, 10'd1023, 4'd3);
		send_move(-15'sd8500, -16'sd17900, 10'd900, 4'd12);
		// random moves
		for (int n = 0; n < 2000; n++) begin
			if ($urandom_range(0, 4) == 0)
				send_move(pick_lat(), pick_lon(), 10'($urandom), 4'($urandom));
			else
				send_move(pick_lat(), pick_lon(), 10'($urandom_range(0, 1023)),
					4'($urandom_range(0, 15)));
		end
		start <= 0;
		waited = 0;
		while (board.pending.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb_compass_offset_position passed");
		end else begin
			$display("tb_compass_offset_position failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("tb_compass_offset_position failed");
		$finish;
	end

endmodule

@@ files.f @@
src/cop_pkg.sv
src/cop_north.sv
src/cop_cidx.sv
src/cop_ldiv.sv
src/compass_offset_position.sv
tb/sv/tb_compass_offset_position.sv
